// ===== sv/pd_joint_torque_homing_assert.svh =====
// Assertion macros used by the checker of the PD joint torque homing block.
`ifndef PD_JOINT_TORQUE_HOMING_ASSERT_SVH
`define PD_JOINT_TORQUE_HOMING_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDJTH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDJTH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pdjth_pkg.sv =====
// Package with the codes and reset values of the PD joint torque homing block.
package pdjth_pkg;

  localparam logic [1:0] MODE_TARGET   = 2'd0;
  localparam logic [1:0] MODE_MEASURED = 2'd1;
  localparam logic [1:0] MODE_TICK     = 2'd2;

  localparam logic [1:0] REG_PROP_GAIN        = 2'd0;
  localparam logic [1:0] REG_DERIV_GAIN       = 2'd1;
  localparam logic [1:0] REG_DRIVE_LIMIT      = 2'd2;
  localparam logic [1:0] REG_SETTLE_THRESHOLD = 2'd3;

  localparam logic [31:0] PROP_GAIN_RST        = 32'd1638400;
  localparam logic [31:0] DERIV_GAIN_RST       = 32'd131072;
  localparam logic [30:0] DRIVE_LIMIT_RST      = 31'd655360;
  localparam logic [30:0] SETTLE_THRESHOLD_RST = 31'd655;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

endpackage

// ===== sv/pd_joint_torque_homing.sv =====
// PD joint torque controller with convergence check and output clamp.
// Samples are written into two tables, one for target and one for measured joints, each with
// one write and one read port and each entry holding position and velocity; s_axis_tready is
// high whenever the sequencer is idle. A tick with both sides ready first walks the tables at
// one joint per cycle to check convergence, then either emits the zero-torque run at one joint
// per cycle while the output is not stalled or computes the torque run joint by joint (table
// read, error subtract, gain multiply, sum and clamp). The output register lets the next joint
// proceed while a result still waits to be taken.
module pd_joint_torque_homing
  import pdjth_pkg::*;
#(
  parameter int NUM_JOINTS = 7
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // joint_index [3:0], joint_position [35:4], joint_velocity [67:36], zero [71:68]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // mode [1:0]
  input  logic [1:0]            s_axis_tuser,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // out_joint [3:0], torque_cmd [35:4], zero [39:36]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // settled [0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int JW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
  localparam logic [JW-1:0] LAST_J = JW'(NUM_JOINTS - 1);
  localparam logic [4:0] NJ = 5'(NUM_JOINTS);

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_ZERO, S_RD, S_ERR, S_MUL, S_SUM
  } state_t;

  state_t state;

  logic [31:0] prop_gain;
  logic [31:0] deriv_gain;
  logic [30:0] drive_limit;
  logic [30:0] settle_threshold;

  logic [63:0] tmem [NUM_JOINTS];
  logic [63:0] mmem [NUM_JOINTS];
  logic [NUM_JOINTS-1:0] tvld;
  logic [NUM_JOINTS-1:0] mvld;
  logic [63:0] tmem_q;
  logic [63:0] mmem_q;
  logic tvld_q;
  logic mvld_q;

  logic target_ready;
  logic measured_ready;
  logic finished;

  logic [JW-1:0] cnt;
  logic [JW-1:0] iss_cnt;
  logic iss_on;
  logic d1;
  logic d1_last;
  logic v2;
  logic v2_last;
  logic fail;

  logic signed [32:0] pe_q;
  logic signed [32:0] ve_q;
  logic signed [65:0] p1;
  logic signed [65:0] p2;

  logic        out_valid;
  logic [3:0]  out_joint;
  logic [31:0] torque_cmd;
  logic        run_end;
  logic        settled;

  logic in_acc;
  logic cfg_wr;
  logic [1:0] mode;
  logic [3:0] joint_index;
  logic [31:0] joint_position;
  logic [31:0] joint_velocity;
  logic idx_ok;
  logic [JW-1:0] wr_addr;
  logic t_wr;
  logic m_wr;
  logic [JW-1:0] rd_addr;

  logic [31:0] tp;
  logic [31:0] tv;
  logic [31:0] mp;
  logic [31:0] mv;
  logic signed [32:0] pe;
  logic signed [32:0] ve;
  logic signed [32:0] thr;
  logic chk_bad;
  logic signed [32:0] pg_s;
  logic signed [32:0] dg_s;
  logic signed [66:0] sum;
  logic signed [50:0] sh;
  logic signed [50:0] lim;
  logic [31:0] clamped;
  logic out_free;
  logic out_load;

  assign s_axis_tready  = (state == S_IDLE);
  assign in_acc         = s_axis_tvalid && s_axis_tready;
  assign mode           = s_axis_tuser;
  assign joint_index    = s_axis_tdata[3:0];
  assign joint_position = s_axis_tdata[35:4];
  assign joint_velocity = s_axis_tdata[67:36];
  assign idx_ok         = ({1'b0, joint_index} < NJ);
  assign wr_addr        = joint_index[JW-1:0];
  assign t_wr = in_acc && !finished && idx_ok && (mode == MODE_TARGET);
  assign m_wr = in_acc && !finished && idx_ok && (mode == MODE_MEASURED);
  assign rd_addr = (state == S_CHK) ? iss_cnt : cnt;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain        <= PROP_GAIN_RST;
      deriv_gain       <= DERIV_GAIN_RST;
      drive_limit      <= DRIVE_LIMIT_RST;
      settle_threshold <= SETTLE_THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_PROP_GAIN:        prop_gain        <= pwdata;
        REG_DERIV_GAIN:       deriv_gain       <= pwdata;
        REG_DRIVE_LIMIT:      drive_limit      <= pwdata[30:0];
        REG_SETTLE_THRESHOLD: settle_threshold <= pwdata[30:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PROP_GAIN:        prdata = prop_gain;
      REG_DERIV_GAIN:       prdata = deriv_gain;
      REG_DRIVE_LIMIT:      prdata = {1'b0, drive_limit};
      REG_SETTLE_THRESHOLD: prdata = {1'b0, settle_threshold};
    endcase
  end

  always_ff @(posedge clk) begin
    if (t_wr) begin
      tmem[wr_addr] <= {joint_position, joint_velocity};
    end
    if (m_wr) begin
      mmem[wr_addr] <= {joint_position, joint_velocity};
    end
    tmem_q <= tmem[rd_addr];
    mmem_q <= mmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tvld   <= '0;
      mvld   <= '0;
      tvld_q <= 1'b0;
      mvld_q <= 1'b0;
    end else begin
      if (t_wr) begin
        tvld[wr_addr] <= 1'b1;
      end
      if (m_wr) begin
        mvld[wr_addr] <= 1'b1;
      end
      tvld_q <= tvld[rd_addr];
      mvld_q <= mvld[rd_addr];
    end
  end

  assign tp = tvld_q ? tmem_q[63:32] : '0;
  assign tv = tvld_q ? tmem_q[31:0]  : '0;
  assign mp = mvld_q ? mmem_q[63:32] : '0;
  assign mv = mvld_q ? mmem_q[31:0]  : '0;
  assign pe = $signed({tp[31], tp}) - $signed({mp[31], mp});
  assign ve = $signed({tv[31], tv}) - $signed({mv[31], mv});

  assign thr     = $signed({2'b00, settle_threshold});
  assign chk_bad = (pe_q > thr) || (pe_q < -thr);

  assign pg_s = $signed({1'b0, prop_gain});
  assign dg_s = $signed({1'b0, deriv_gain});

  assign sum = 67'(p1) + 67'(p2);
  assign sh  = sum[66:16];
  assign lim = $signed({20'd0, drive_limit});
  always_comb begin
    if (sh > lim) begin
      clamped = 32'(lim);
    end else if (sh < -lim) begin
      clamped = 32'(-lim);
    end else begin
      clamped = sh[31:0];
    end
  end

  assign out_free = !out_valid || m_axis_tready;
  assign out_load = out_free && ((state == S_ZERO) || (state == S_SUM));

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      target_ready   <= 1'b0;
      measured_ready <= 1'b0;
      finished       <= 1'b0;
      out_valid      <= 1'b0;
      cnt            <= '0;
      iss_cnt        <= '0;
      iss_on         <= 1'b0;
      d1             <= 1'b0;
      d1_last        <= 1'b0;
      v2             <= 1'b0;
      v2_last        <= 1'b0;
      fail           <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc && !finished) begin
            case (mode)
              MODE_TARGET: begin
                if (idx_ok && s_axis_tlast) begin
                  target_ready <= 1'b1;
                end
              end
              MODE_MEASURED: begin
                if (idx_ok && s_axis_tlast) begin
                  measured_ready <= 1'b1;
                end
              end
              MODE_TICK: begin
                if (target_ready && measured_ready) begin
                  state   <= S_CHK;
                  iss_cnt <= '0;
                  iss_on  <= 1'b1;
                  d1      <= 1'b0;
                  v2      <= 1'b0;
                  fail    <= 1'b0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CHK: begin
          if (iss_on) begin
            if (iss_cnt == LAST_J) begin
              iss_on <= 1'b0;
            end else begin
              iss_cnt <= iss_cnt + 1'b1;
            end
          end
          d1      <= iss_on;
          d1_last <= iss_on && (iss_cnt == LAST_J);
          v2      <= d1;
          v2_last <= d1_last;
          if (d1) begin
            pe_q <= pe;
          end
          if (v2) begin
            if (chk_bad) begin
              fail <= 1'b1;
            end
            if (v2_last) begin
              cnt   <= '0;
              state <= (fail || chk_bad) ? S_RD : S_ZERO;
            end
          end
        end
        S_ZERO: begin
          if (out_free) begin
            out_joint  <= 4'(cnt);
            torque_cmd <= '0;
            run_end    <= (cnt == LAST_J);
            settled    <= 1'b1;
            if (cnt == LAST_J) begin
              finished <= 1'b1;
              state    <= S_IDLE;
            end else begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_RD: begin
          state <= S_ERR;
        end
        S_ERR: begin
          pe_q  <= pe;
          ve_q  <= ve;
          state <= S_MUL;
        end
        S_MUL: begin
          p1    <= pg_s * pe_q;
          p2    <= dg_s * ve_q;
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_free) begin
            out_joint  <= 4'(cnt);
            torque_cmd <= clamped;
            run_end    <= (cnt == LAST_J);
            settled    <= 1'b0;
            if (cnt == LAST_J) begin
              state <= S_IDLE;
            end else begin
              cnt   <= cnt + 1'b1;
              state <= S_RD;
            end
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'd0, torque_cmd, out_joint};
  assign m_axis_tuser  = settled;
  assign m_axis_tlast  = run_end;

endmodule

// ===== sv/pdjth_checker.sv =====
// Port-level checker for the PD joint torque homing block, bound to its top level.
`include "pd_joint_torque_homing_assert.svh"

module pdjth_checker #(
  parameter int NUM_JOINTS = 7
) (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  `PDJTH_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output transaction dropped while stalled")
  `PDJTH_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output transaction changed")
  `PDJTH_ASSERT_SAME(a_settled_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[35:4] == 32'd0, "settled run carries nonzero torque")
  `PDJTH_ASSERT_SAME(a_last_joint, m_axis_tvalid && m_axis_tlast, m_axis_tdata[3:0] == 4'(NUM_JOINTS - 1), "run ends on a joint other than the last")

endmodule

bind pd_joint_torque_homing pdjth_checker #(.NUM_JOINTS(NUM_JOINTS)) u_pdjth_checker (.*);

// ===== tb/tb_top.sv =====
// Self-checking testbench for the PD joint torque homing block, with a predicting scoreboard.
module tb_top
  import pdjth_pkg::*;
;

  localparam int JOINTS = 7;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [1:0] MODE_RESERVED = 2'd3;

  typedef enum {TRAFFIC_SLOW_SENDER, TRAFFIC_SLOW_RECEIVER, TRAFFIC_FULL_RATE} traffic_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  joint;
    logic [31:0] pos;
    logic [31:0] vel;
    logic        last;
  } joint_sample_t;

  typedef struct packed {
    logic [3:0]  joint;
    logic [31:0] torque;
    logic        run_end;
    logic        settled;
  } torque_cmd_t;

  class pd_torque_scoreboard;
    logic [31:0] prop_gain;
    logic [31:0] deriv_gain;
    logic [30:0] drive_limit;
    logic [30:0] settle_threshold;
    logic [31:0] tgt_pos [JOINTS];
    logic [31:0] tgt_vel [JOINTS];
    logic [31:0] meas_pos [JOINTS];
    logic [31:0] meas_vel [JOINTS];
    bit tgt_ready;
    bit meas_ready;
    bit finished;
    torque_cmd_t pending_torques[$];
    int unsigned mismatches;
    int unsigned effective_items;
    int unsigned runs;
    int unsigned settled_runs;
    int unsigned checked;

    function new();
      prop_gain = PROP_GAIN_RST;
      deriv_gain = DERIV_GAIN_RST;
      drive_limit = DRIVE_LIMIT_RST;
      settle_threshold = SETTLE_THRESHOLD_RST;
      foreach (tgt_pos[j]) begin
        tgt_pos[j] = '0;
        tgt_vel[j] = '0;
        meas_pos[j] = '0;
        meas_vel[j] = '0;
      end
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_PROP_GAIN: prop_gain = value;
        REG_DERIV_GAIN: deriv_gain = value;
        REG_DRIVE_LIMIT: drive_limit = value[30:0];
        REG_SETTLE_THRESHOLD: settle_threshold = value[30:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_PROP_GAIN: return prop_gain;
        REG_DERIV_GAIN: return deriv_gain;
        REG_DRIVE_LIMIT: return {1'b0, drive_limit};
        default: return {1'b0, settle_threshold};
      endcase
    endfunction

    function logic signed [32:0] pos_error(int j);
      return $signed({tgt_pos[j][31], tgt_pos[j]}) - $signed({meas_pos[j][31], meas_pos[j]});
    endfunction

    function bit within_threshold();
      logic signed [33:0] pos_gap;
      for (int j = 0; j < JOINTS; j++) begin
        pos_gap = pos_error(j);
        if (pos_gap < 0) pos_gap = -pos_gap;
        if (pos_gap > $signed({3'b000, settle_threshold})) return 1'b0;
      end
      return 1'b1;
    endfunction

    function bit tick_would_settle();
      return tgt_ready && meas_ready && !finished && within_threshold();
    endfunction

    function logic [31:0] predict_torque(int j);
      logic signed [69:0] gain_p, gain_d, err_p, err_d, acc, lim;
      gain_p = {38'd0, prop_gain};
      gain_d = {38'd0, deriv_gain};
      err_p = pos_error(j);
      err_d = $signed({tgt_vel[j][31], tgt_vel[j]}) - $signed({meas_vel[j][31], meas_vel[j]});
      acc = (gain_p * err_p + gain_d * err_d) >>> 16;
      lim = {39'd0, drive_limit};
      if (acc > lim) acc = lim;
      else if (acc < -lim) acc = -lim;
      return acc[31:0];
    endfunction

    function void note_sample(joint_sample_t s);
      torque_cmd_t t;
      bit settle;
      if (finished) return;
      if (s.mode == MODE_TARGET || s.mode == MODE_MEASURED) begin
        if (s.joint >= JOINTS) return;
        effective_items++;
        if (s.mode == MODE_TARGET) begin
          tgt_pos[s.joint] = s.pos;
          tgt_vel[s.joint] = s.vel;
          if (s.last) tgt_ready = 1'b1;
        end else begin
          meas_pos[s.joint] = s.pos;
          meas_vel[s.joint] = s.vel;
          if (s.last) meas_ready = 1'b1;
        end
        return;
      end
      if (s.mode != MODE_TICK) return;
      effective_items++;
      if (!(tgt_ready && meas_ready)) return;
      settle = within_threshold();
      for (int j = 0; j < JOINTS; j++) begin
        t.joint = 4'(j);
        t.torque = settle ? 32'd0 : predict_torque(j);
        t.run_end = (j == JOINTS - 1);
        t.settled = settle;
        pending_torques = {pending_torques, t};
      end
      runs++;
      if (settle) begin
        settled_runs++;
        finished = 1'b1;
      end
    endfunction

    function void check_torque(torque_cmd_t got);
      torque_cmd_t want;
      checked++;
      if (pending_torques.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected torque transaction: joint %0d torque %h run_end %b settled %b",
                 $time, got.joint, got.torque, got.run_end, got.settled);
        return;
      end
      want = pending_torques.pop_front();
      if (got.joint !== want.joint) begin
        mismatches++;
        $display("%0t: out_joint expected %0d actual %0d", $time, want.joint, got.joint);
      end
      if (got.torque !== want.torque) begin
        mismatches++;
        $display("%0t: torque_cmd of joint %0d expected %h actual %h",
                 $time, want.joint, want.torque, got.torque);
      end
      if (got.run_end !== want.run_end) begin
        mismatches++;
        $display("%0t: run_end of joint %0d expected %b actual %b",
                 $time, want.joint, want.run_end, got.run_end);
      end
      if (got.settled !== want.settled) begin
        mismatches++;
        $display("%0t: settled of joint %0d expected %b actual %b",
                 $time, want.joint, want.settled, got.settled);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // joint_index [3:0], joint_position [35:4], joint_velocity [67:36], zero [71:68]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // mode [1:0]
  logic [1:0]            s_axis_tuser = MODE_TARGET;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // out_joint [3:0], torque_cmd [35:4], zero [39:36]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // settled [0]
  logic                  m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [3:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  traffic_t traffic = TRAFFIC_SLOW_SENDER;
  pd_torque_scoreboard sb;

  pd_joint_torque_homing #(
    .NUM_JOINTS(JOINTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= $urandom_range(99) >= (traffic == TRAFFIC_SLOW_SENDER ? 52 :
                                            traffic == TRAFFIC_SLOW_RECEIVER ? 37 : 0);
  end

  always @(posedge clk) begin
    torque_cmd_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.joint = m_axis_tdata[3:0];
      got.torque = m_axis_tdata[35:4];
      got.run_end = m_axis_tlast;
      got.settled = m_axis_tuser;
      sb.check_torque(got);
    end
  end

  function automatic logic [31:0] small_word();
    return 32'($urandom_range(1 << 19)) - 32'(1 << 18);
  endfunction

  function automatic logic [31:0] jitter();
    return 32'($urandom_range(1 << 12)) - 32'(1 << 11);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2: begin
        case ($urandom_range(3))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return small_word();
    endcase
  endfunction

  task automatic send_sample(input logic [1:0] mode, input logic [3:0] joint,
                             input logic [31:0] pos, input logic [31:0] vel, input logic last);
    joint_sample_t s;
    s.mode = mode;
    s.joint = joint;
    s.pos = pos;
    s.vel = vel;
    s.last = last;
    while ($urandom_range(99) < (traffic == TRAFFIC_SLOW_SENDER ? 37 :
                                 traffic == TRAFFIC_SLOW_RECEIVER ? 52 : 0)) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata = {4'd0, vel, pos, joint};
    s_axis_tuser = mode;
    s_axis_tlast = last;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_sample(s);
    @(negedge clk);
  endtask

  task automatic send_tick(input bit allow_settle);
    if (!allow_settle && sb.tick_would_settle()) return;
    send_sample(MODE_TICK, 4'($urandom()), $urandom(), $urandom(), 1'($urandom()));
  endtask

  task automatic send_set(input logic [1:0] mode);
    logic [31:0] pos;
    for (int j = 0; j < JOINTS; j++) begin
      if (j < JOINTS - 1 && $urandom_range(9) == 0) continue;
      pos = (mode == MODE_MEASURED && $urandom_range(1)) ? sb.tgt_pos[j] + jitter() : rand_word();
      send_sample(mode, 4'(j), pos, rand_word(), j == JOINTS - 1);
    end
  endtask

  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (sb.pending_torques.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] readback;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    if (readback !== sb.reg_value(idx)) begin
      sb.mismatches++;
      $display("%0t: register %0d read back expected %h actual %h",
               $time, idx, sb.reg_value(idx), readback);
    end
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned start;
    start = sb.effective_items;
    while (sb.effective_items - start < quota) begin
      case ($urandom_range(9))
        0, 1, 2: send_set(MODE_TARGET);
        3, 4, 5: send_set(MODE_MEASURED);
        6, 7: begin
          repeat ($urandom_range(1, 2)) begin
            send_sample($urandom_range(1) ? MODE_MEASURED : MODE_TARGET,
                        4'($urandom_range(JOINTS - 1)), rand_word(), rand_word(),
                        1'($urandom()));
          end
        end
        default: begin
          if ($urandom_range(1)) begin
            send_sample(MODE_RESERVED, 4'($urandom()), rand_word(), rand_word(),
                        1'($urandom()));
          end else begin
            send_sample($urandom_range(1) ? MODE_MEASURED : MODE_TARGET,
                        4'($urandom_range(15, JOINTS)), rand_word(), rand_word(),
                        1'($urandom()));
          end
        end
      endcase
      if ($urandom_range(9) < 6) repeat ($urandom_range(1, 2)) send_tick(1'b0);
    end
  endtask

  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    send_tick(1'b0);
    send_sample(MODE_TARGET, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_sample(MODE_MEASURED, 4'(JOINTS), 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_sample(MODE_RESERVED, 4'd0, 32'h0000_0001, 32'h0000_0001, 1'b1);
    send_sample(MODE_MEASURED, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_tick(1'b0);
    send_sample(MODE_TARGET, 4'(JOINTS - 1), 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_tick(1'b0);
    send_sample(MODE_MEASURED, 4'd0, 32'd655, 32'd0, 1'b0);
    send_sample(MODE_TARGET, 4'(JOINTS - 1), 32'd656, 32'd0, 1'b0);
    send_tick(1'b0);
    send_sample(MODE_TARGET, 4'(JOINTS - 1), -32'sd656, 32'd0, 1'b0);
    send_tick(1'b0);
    send_sample(MODE_TARGET, 4'd3, 32'h0001_0000, 32'hFFFF_0000, 1'b0);
    send_tick(1'b0);
    drain_results();

    program_reg(REG_PROP_GAIN, 32'hFFFF_FFFF);
    program_reg(REG_DERIV_GAIN, 32'hFFFF_FFFF);
    program_reg(REG_DRIVE_LIMIT, 32'hFFFF_FFFF);
    program_reg(REG_SETTLE_THRESHOLD, 32'd0);
    send_sample(MODE_TARGET, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_sample(MODE_MEASURED, 4'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_tick(1'b0);
    send_sample(MODE_MEASURED, 4'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    send_sample(MODE_TARGET, 4'd0, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_tick(1'b0);
    run_random(10);
    drain_results();
    run_random(10);
    drain_results();

    traffic = TRAFFIC_SLOW_RECEIVER;
    program_reg(REG_PROP_GAIN, 32'd0);
    program_reg(REG_DERIV_GAIN, $urandom_range(1 << 20));
    program_reg(REG_DRIVE_LIMIT, $urandom_range(1 << 24, 1));
    program_reg(REG_SETTLE_THRESHOLD, $urandom_range(1 << 12));
    run_random(15);
    drain_results();

    program_reg(REG_PROP_GAIN, $urandom());
    program_reg(REG_DERIV_GAIN, 32'd0);
    program_reg(REG_DRIVE_LIMIT, 32'd0);
    program_reg(REG_SETTLE_THRESHOLD, $urandom_range(1 << 10));
    run_random(15);
    drain_results();

    traffic = TRAFFIC_FULL_RATE;
    program_reg(REG_PROP_GAIN, $urandom_range(1 << 22));
    program_reg(REG_DERIV_GAIN, $urandom_range(1 << 20));
    program_reg(REG_DRIVE_LIMIT, $urandom_range(1 << 22, 1 << 16));
    program_reg(REG_SETTLE_THRESHOLD, $urandom_range(1 << 10));
    run_random(15);
    drain_results();

    program_reg(REG_SETTLE_THRESHOLD, 32'h7FFF_FFFF);
    for (int j = 0; j < JOINTS; j++) begin
      send_sample(MODE_TARGET, 4'(j), j == 0 ? 32'h7FFF_FFFF : small_word(), rand_word(),
                  j == JOINTS - 1);
    end
    for (int j = 0; j < JOINTS; j++) begin
      send_sample(MODE_MEASURED, 4'(j), j == 0 ? 32'd0 : sb.tgt_pos[j] + jitter(),
                  rand_word(), j == JOINTS - 1);
    end
    send_tick(1'b1);
    send_sample(MODE_TARGET, 4'd0, 32'h4000_0000, 32'd0, 1'b1);
    send_sample(MODE_MEASURED, 4'd1, 32'hC000_0000, 32'd0, 1'b1);
    send_tick(1'b1);
    send_sample(MODE_RESERVED, 4'd2, $urandom(), $urandom(), 1'b0);
    send_tick(1'b1);
    drain_results();
    program_reg(REG_PROP_GAIN, PROP_GAIN_RST);

    $display("Run covered %0d processed samples and ticks, %0d torque runs (%0d settled),",
             sb.effective_items, sb.runs, sb.settled_runs);
    $display("and %0d torque transactions under zero, full-scale and random gains and limits.",
             sb.checked);
    if (sb.mismatches == 0 && sb.pending_torques.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
